>>> rtl/core/haar_2d_multilevel_transform_macros.svh
// Assertion macros for the Haar transform block and its checker.
// Used by hdt_checker.sv; relies on clk and rst_n in the scope of use.
`ifndef HAAR_2D_MULTILEVEL_TRANSFORM_MACROS_SVH
`define HAAR_2D_MULTILEVEL_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled in reset
`define HDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdt assertion failed");

// Next-cycle implication, disabled in reset
`define HDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdt assertion failed");

`endif

>>> rtl/core/hdt_pkg.sv
// Shared constants, types and codes of the Haar transform block.
// No dependencies.
`timescale 1ns / 1ps
package hdt_pkg;
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int COEF_WIDTH = 32;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DIM_W      = 8;
    localparam int LVL_W      = 3;
    localparam int PIX_W      = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int BLK_W      = 6;
    localparam int QDIM_W     = 7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_XFORM = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] index;
        logic [PIX_W-1:0]  value;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY_IN,
        ST_LVL_INIT,
        ST_LVL_MUL,
        ST_BLK_RD,
        ST_BLK_SUM,
        ST_BLK_WR,
        ST_COPY_BACK
    } seq_state_t;
endpackage

>>> rtl/core/hdt_item_if.sv
// Input word channel: command, pixel index and pixel value.
// Depends on hdt_pkg.
`timescale 1ns / 1ps
interface hdt_item_if;
    import hdt_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [ADDR_W-1:0]   pixel_index;
    logic [PIX_W-1:0]    pixel_value;
    modport source (output valid, cmd, pixel_index, pixel_value, input ready);
    modport sink (input valid, cmd, pixel_index, pixel_value, output ready);
endinterface

>>> rtl/core/hdt_result_if.sv
// Result word channel: coefficient and transform completion flag.
// Depends on hdt_pkg.
`timescale 1ns / 1ps
interface hdt_result_if;
    import hdt_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coefficient;
    logic                         transform_done;
    modport source (output valid, coefficient, transform_done, input ready);
    modport sink (input valid, coefficient, transform_done, output ready);
endinterface

>>> rtl/core/hdt_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on hdt_pkg.
`timescale 1ns / 1ps
interface hdt_cfg_if;
    import hdt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/hdt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module hdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

>>> rtl/core/hdt_front.sv
// Front end: accepts input words, decodes the command, queues two entries.
// Depends on hdt_pkg and hdt_item_if.
`timescale 1ns / 1ps
module hdt_front (
    input  logic           clk,
    input  logic           rst_n,
    hdt_item_if.sink       item,
    output hdt_pkg::head_t head,
    input  logic           pop
);
    import hdt_pkg::*;

    item_t      q_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      in_item;

    // Decode the incoming word
    always_comb
    begin
        in_item.cmd   = cmd_t'(item.cmd);
        in_item.index = item.pixel_index;
        in_item.value = item.pixel_value;
    end

    assign item.ready = (cnt_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_reg[rptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold queued words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= in_item;
        end
    end
endmodule

>>> rtl/core/hdt_back.sv
// Back end: executes loads, reads and the multilevel transform sequence.
// Depends on hdt_pkg, hdt_ram, hdt_result_if and hdt_cfg_if.
`timescale 1ns / 1ps
module hdt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  hdt_pkg::head_t head,
    output logic           pop,
    hdt_result_if.source   result,
    hdt_cfg_if.sink        cfg
);
    import hdt_pkg::*;

    localparam int EXT_W = COEF_WIDTH + 5;
    localparam logic signed [EXT_W-1:0] SAT_HI =
        EXT_W'((64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

    function automatic logic [COEF_WIDTH-1:0] coef_sat(input logic signed [EXT_W-1:0] v);
        if (v > SAT_HI)
        begin
            return SAT_HI[COEF_WIDTH-1:0];
        end
        if (v < SAT_LO)
        begin
            return SAT_LO[COEF_WIDTH-1:0];
        end
        return v[COEF_WIDTH-1:0];
    endfunction

    seq_state_t        st_reg, st_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic              cp_vld_reg, cp_vld_next;
    logic [ADDR_W-1:0] cp_addr_reg, cp_addr_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [QDIM_W-1:0] qw_reg, qw_next, qh_reg, qh_next;
    logic [ADDR_W-1:0] qhw_reg, qhw_next;
    logic [BLK_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [1:0]        sub_reg, sub_next;
    logic [ADDR_W-1:0] srow_reg, srow_next, drow_reg, drow_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [1:0]        rd_sub_reg, rd_sub_next;
    logic              pend_reg, pend_next;
    logic              pend_rd_reg, pend_rd_next;
    logic              out_vld_reg, out_vld_next;
    logic              out_load;
    logic [COEF_WIDTH-1:0] out_coef_next;
    logic              out_done_next;
    logic [COEF_WIDTH-1:0] out_coef_reg;
    logic              out_done_reg;
    logic [DIM_W-1:0]  w_reg, h_reg;
    logic [LVL_W-1:0]  lvls_reg;
    logic [COEF_WIDTH-1:0] pix_reg [4];

    logic [DIM_W-1:0]  w_use, h_use;
    logic              out_free, take;

    logic              src_we, src_re, res_we, res_re;
    logic [ADDR_W-1:0] src_waddr, src_raddr, res_waddr, res_raddr;
    logic [COEF_WIDTH-1:0] src_wdata, src_rdata, res_wdata, res_rdata;

    logic signed [EXT_W-1:0] pa, pb, pc, pd, sum, half, scaled;

    hdt_ram #(.WIDTH(COEF_WIDTH), .DEPTH(DEPTH)) u_src (
        .clk(clk), .we(src_we), .waddr(src_waddr), .wdata(src_wdata),
        .re(src_re), .raddr(src_raddr), .rdata(src_rdata)
    );

    hdt_ram #(.WIDTH(COEF_WIDTH), .DEPTH(DEPTH)) u_res (
        .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .re(res_re), .raddr(res_raddr), .rdata(res_rdata)
    );

    // Clamp the image size to the store
    always_comb
    begin
        w_use = (w_reg < DIM_W'(2)) ? DIM_W'(2) :
                (w_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_reg;
        h_use = (h_reg < DIM_W'(2)) ? DIM_W'(2) :
                (h_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : h_reg;
    end

    // Block arithmetic: signed sum, floor halving, times five for the detail bands, saturate
    always_comb
    begin
        pa = EXT_W'($signed(pix_reg[0]));
        pb = EXT_W'($signed(pix_reg[1]));
        pc = EXT_W'($signed(pix_reg[2]));
        pd = EXT_W'($signed(pix_reg[3]));
        case (sub_reg)
            2'd0:    sum = pa + pb + pc + pd;
            2'd1:    sum = pa + pc - pb - pd;
            2'd2:    sum = pa + pb - pc - pd;
            default: sum = pa - pb - pc + pd;
        endcase
        half   = sum >>> 1;
        scaled = (sub_reg == 2'd0) ? half : (half <<< 2) + half;
    end

    assign cfg.ready = 1'b1;
    assign out_free  = !out_vld_reg || result.ready;
    assign take      = (st_reg == ST_IDLE) && head.valid && !pend_reg && out_free;
    assign pop       = take;

    assign result.valid          = out_vld_reg;
    assign result.coefficient    = out_coef_reg;
    assign result.transform_done = out_done_reg;

    // Sequencer: next state, store ports and result register
    always_comb
    begin
        st_next      = st_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        cp_vld_next  = 1'b0;
        cp_addr_next = cnt_reg[ADDR_W-1:0];
        lvl_next     = lvl_reg;
        qw_next      = qw_reg;
        qh_next      = qh_reg;
        qhw_next     = qhw_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        sub_next     = sub_reg;
        srow_next    = srow_reg;
        drow_next    = drow_reg;
        rd_vld_next  = 1'b0;
        rd_sub_next  = sub_reg;
        pend_next    = 1'b0;
        pend_rd_next = 1'b0;
        out_load     = 1'b0;
        out_coef_next = '0;
        out_done_next = 1'b0;

        src_we    = 1'b0;
        src_waddr = head.item.index;
        src_wdata = COEF_WIDTH'(head.item.value);
        src_re    = 1'b0;
        src_raddr = cnt_reg[ADDR_W-1:0];
        res_we    = 1'b0;
        res_waddr = cp_addr_reg;
        res_wdata = src_rdata;
        res_re    = 1'b0;
        res_raddr = head.item.index;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    unique case (head.item.cmd)
                        CMD_LOAD:
                        begin
                            src_we    = 1'b1;
                            pend_next = 1'b1;
                        end
                        CMD_READ:
                        begin
                            res_re       = 1'b1;
                            pend_next    = 1'b1;
                            pend_rd_next = 1'b1;
                        end
                        CMD_XFORM:
                        begin
                            cnt_next   = '0;
                            total_next = CNT_W'(w_use * h_use);
                            st_next    = ST_COPY_IN;
                        end
                        default:
                        begin
                            pend_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_COPY_IN, ST_COPY_BACK:
            begin
                if (cnt_reg < total_reg)
                begin
                    cnt_next    = cnt_reg + CNT_W'(1);
                    cp_vld_next = 1'b1;
                    if (st_reg == ST_COPY_IN)
                    begin
                        src_re = 1'b1;
                    end
                    else
                    begin
                        res_re    = 1'b1;
                        res_raddr = cnt_reg[ADDR_W-1:0];
                    end
                end
                if (st_reg == ST_COPY_IN)
                begin
                    res_we = cp_vld_reg;
                end
                else
                begin
                    src_we    = cp_vld_reg;
                    src_waddr = cp_addr_reg;
                    src_wdata = res_rdata;
                end
                if (cnt_reg == total_reg)
                begin
                    if (st_reg == ST_COPY_IN)
                    begin
                        lvl_next = '0;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LVL_W'(1);
                    end
                    st_next = ST_LVL_INIT;
                end
            end
            ST_LVL_INIT:
            begin
                if (lvl_reg == lvls_reg)
                begin
                    // Report completion once the result register frees up
                    if (out_free)
                    begin
                        out_load      = 1'b1;
                        out_done_next = 1'b1;
                        st_next       = ST_IDLE;
                    end
                end
                else
                begin
                    qw_next = QDIM_W'(w_use >> (4'(lvl_reg) + 4'd1));
                    qh_next = QDIM_W'(h_use >> (4'(lvl_reg) + 4'd1));
                    st_next = ST_LVL_MUL;
                end
            end
            ST_LVL_MUL:
            begin
                qhw_next = ADDR_W'(qh_reg * w_use);
                if ((qw_reg == '0) || (qh_reg == '0))
                begin
                    // Empty quadrant: the level leaves both stores unchanged
                    lvl_next = lvl_reg + LVL_W'(1);
                    st_next  = ST_LVL_INIT;
                end
                else
                begin
                    x_next    = '0;
                    y_next    = '0;
                    sub_next  = '0;
                    srow_next = '0;
                    drow_next = '0;
                    st_next   = ST_BLK_RD;
                end
            end
            ST_BLK_RD:
            begin
                src_re      = 1'b1;
                src_raddr   = ADDR_W'(CNT_W'(srow_reg) + (sub_reg[1] ? CNT_W'(w_use) : '0)
                              + CNT_W'({x_reg, sub_reg[0]}));
                rd_vld_next = 1'b1;
                sub_next    = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    st_next = ST_BLK_SUM;
                end
            end
            ST_BLK_SUM:
            begin
                st_next = ST_BLK_WR;
            end
            ST_BLK_WR:
            begin
                res_we    = 1'b1;
                res_wdata = coef_sat(scaled);
                res_waddr = ADDR_W'(CNT_W'(drow_reg) + CNT_W'(x_reg)
                            + (sub_reg[0] ? CNT_W'(qw_reg) : '0)
                            + (sub_reg[1] ? CNT_W'(qhw_reg) : '0));
                sub_next  = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    st_next = ST_BLK_RD;
                    if (x_reg == BLK_W'(qw_reg - QDIM_W'(1)))
                    begin
                        x_next    = '0;
                        y_next    = y_reg + BLK_W'(1);
                        srow_next = ADDR_W'(CNT_W'(srow_reg) + CNT_W'({w_use, 1'b0}));
                        drow_next = ADDR_W'(CNT_W'(drow_reg) + CNT_W'(w_use));
                        if (y_reg == BLK_W'(qh_reg - QDIM_W'(1)))
                        begin
                            cnt_next = '0;
                            st_next  = ST_COPY_BACK;
                        end
                    end
                    else
                    begin
                        x_next = x_reg + BLK_W'(1);
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        // Load the result register from a finished load, read or no-op
        if (pend_reg)
        begin
            out_load      = 1'b1;
            out_coef_next = pend_rd_reg ? res_rdata : '0;
        end

        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= ST_IDLE;
            cnt_reg     <= '0;
            total_reg   <= '0;
            cp_vld_reg  <= 1'b0;
            lvl_reg     <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            sub_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            pend_reg    <= 1'b0;
            pend_rd_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            w_reg       <= DIM_W'(MAX_WIDTH);
            h_reg       <= DIM_W'(MAX_HEIGHT);
            lvls_reg    <= LVL_W'(1);
        end
        else
        begin
            st_reg      <= st_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            cp_vld_reg  <= cp_vld_next;
            lvl_reg     <= lvl_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            sub_reg     <= sub_next;
            rd_vld_reg  <= rd_vld_next;
            pend_reg    <= pend_next;
            pend_rd_reg <= pend_rd_next;
            out_vld_reg <= out_vld_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_WIDTH:  w_reg    <= cfg.data;
                    REG_HEIGHT: h_reg    <= cfg.data;
                    REG_LEVELS: lvls_reg <= cfg.data[LVL_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cp_addr_reg <= cp_addr_next;
        qw_reg      <= qw_next;
        qh_reg      <= qh_next;
        qhw_reg     <= qhw_next;
        srow_reg    <= srow_next;
        drow_reg    <= drow_next;
        rd_sub_reg  <= rd_sub_next;
        if (rd_vld_reg)
        begin
            pix_reg[rd_sub_reg] <= src_rdata;
        end
        if (out_load)
        begin
            out_coef_reg <= out_coef_next;
            out_done_reg <= out_done_next;
        end
    end
endmodule

>>> rtl/core/haar_2d_multilevel_transform.sv
// Top level of the multilevel 2D Haar transform block.
// Depends on hdt_pkg, the channel interfaces, hdt_front and hdt_back.
`timescale 1ns / 1ps
// Usage:
//   item   : input words {cmd, pixel_index, pixel_value}. Load writes a pixel
//            into the source store, read returns a result store entry,
//            transform runs the configured number of levels.
//   result : one word per input word {coefficient, transform_done}.
//   cfg    : register writes {index, data}, always ready; write only while idle.
// A two-entry queue sits between the front end and the executing back end.
// Loads, reads and no-ops pass from the queue head through a pending flag into
// the result register; the back end takes the next word only after that load.
// A transform copies the image into the result store, then per level runs the
// setup states ST_LVL_INIT and ST_LVL_MUL, for each 2x2 block 4 source reads,
// one settle and 4 result writes over the single write port, and a copy back
// into the source store; a level with an empty quadrant runs only its setup
// states, and ST_LVL_INIT finally posts the done word.
// Reset empties the queue and result register and restores the registers to
// width 128, height 128, one level; the stores are not cleared.
// When the receiver stalls, the result word holds, the back end stops at the
// next word and the queue fills, after which item ready drops.
module haar_2d_multilevel_transform (
    input logic          clk,
    input logic          rst_n,
    hdt_item_if.sink     item,
    hdt_result_if.source result,
    hdt_cfg_if.sink      cfg
);
    import hdt_pkg::*;

    head_t head;
    logic  pop;

    hdt_front u_front (
        .clk(clk), .rst_n(rst_n), .item(item), .head(head), .pop(pop)
    );

    hdt_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
        .result(result), .cfg(cfg)
    );
endmodule

>>> rtl/core/hdt_checker.sv
// Port-level checker for the Haar transform block, bound to the top level.
// Depends on hdt_pkg and haar_2d_multilevel_transform_macros.svh.
`timescale 1ns / 1ps
`include "haar_2d_multilevel_transform_macros.svh"
module hdt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [hdt_pkg::COEF_WIDTH-1:0]  out_coef,
    input logic                            out_done
);
    import hdt_pkg::*;

    logic [2:0] open_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Track words accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_reg + 3'(in_acc) - 3'(out_acc);
        end
    end

    `HDT_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_coef) && $stable(out_done))
    `HDT_ASSERT_IMP(a_done_zero, out_valid && out_done, out_coef == '0)
    `HDT_ASSERT_IMP(a_no_extra, out_acc, open_reg != 3'd0)
    `HDT_ASSERT_IMP(a_bounded, 1'b1, open_reg <= 3'd4)
endmodule

bind haar_2d_multilevel_transform hdt_checker u_hdt_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(item.valid),
    .in_ready(item.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .out_coef(result.coefficient),
    .out_done(result.transform_done)
);

>>> verif/tb_haar_2d_multilevel_transform.sv
// Testbench for the multilevel 2D Haar transform block: directed and random
// load/transform/read traffic checked against a predictor of the stores.
// Depends on hdt_pkg, the channel interfaces and the block's RTL.
`timescale 1ns / 1ps
module tb_haar_2d_multilevel_transform;
    import hdt_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEM_TARGET = 1550;

    typedef struct {
        logic [COEF_WIDTH-1:0] coefficient;
        logic                  transform_done;
    } result_word_t;

    logic clk;
    logic rst_n;

    hdt_item_if   item ();
    hdt_result_if result ();
    hdt_cfg_if    cfg ();

    haar_2d_multilevel_transform dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // Predicted stores, written flags and register copies
    longint       src_mem [DEPTH];
    longint       res_mem [DEPTH];
    bit           src_ok  [DEPTH];
    bit           res_ok  [DEPTH];
    int unsigned  cur_width;
    int unsigned  cur_height;
    int unsigned  cur_levels;

    result_word_t pending_words [$];
    int           send_gap_pct;
    int           recv_stall_pct;
    int           mismatches;
    int           words_checked;
    int           items_sent;
    int           xforms_sent;
    int           reads_sent;
    int           cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on the cycle count
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d words still due",
                         cycles, pending_words.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic longint coef_clip(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COEF_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic int unsigned dim_clip(int unsigned v, int unsigned maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // Run every Mallat level over the predicted stores
    task automatic haar_levels();
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned qw;
        int unsigned qh;
        int unsigned r0;
        int unsigned r1;
        longint a, b, c, d;
        w = dim_clip(cur_width, MAX_WIDTH);
        h = dim_clip(cur_height, MAX_HEIGHT);
        total = w * h;
        for (int i = 0; i < total; i++)
        begin
            res_mem[i] = src_mem[i];
            res_ok[i] = 1'b1;
        end
        for (int k = 0; k < cur_levels; k++)
        begin
            qw = w >> (k + 1);
            qh = h >> (k + 1);
            for (int y = 0; y < qh; y++)
            begin
                for (int x = 0; x < qw; x++)
                begin
                    r0 = 2 * y * w;
                    r1 = (2 * y + 1) * w;
                    a = src_mem[r0 + 2 * x];
                    b = src_mem[r0 + 2 * x + 1];
                    c = src_mem[r1 + 2 * x];
                    d = src_mem[r1 + 2 * x + 1];
                    res_mem[y * w + x] = coef_clip((a + b + c + d) >>> 1);
                    res_mem[y * w + x + qw] = coef_clip(((a + c - b - d) >>> 1) * 5);
                    res_mem[(y + qh) * w + x] = coef_clip(((a + b - c - d) >>> 1) * 5);
                    res_mem[(y + qh) * w + x + qw] =
                        coef_clip(((a - b - c + d) >>> 1) * 5);
                end
            end
            for (int i = 0; i < total; i++)
                src_mem[i] = res_mem[i];
        end
    endtask

    // Expected result word of one accepted item
    task automatic predict_word(cmd_t op, logic [ADDR_W-1:0] idx, logic [PIX_W-1:0] pix);
        result_word_t rw;
        rw.coefficient = '0;
        rw.transform_done = 1'b0;
        case (op)
            CMD_LOAD:
            begin
                src_mem[idx] = longint'(pix);
                src_ok[idx] = 1'b1;
            end
            CMD_XFORM:
            begin
                haar_levels();
                rw.transform_done = 1'b1;
            end
            CMD_READ:
                rw.coefficient = res_mem[idx][COEF_WIDTH-1:0];
            default:
                ;
        endcase
        pending_words.push_back(rw);
    endtask

    // Send one input word, with random gaps before it
    task automatic send_word(cmd_t op, logic [ADDR_W-1:0] idx, logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_gap_pct)
        begin
            @(negedge clk);
            item.valid <= 1'b0;
            item.cmd <= CMD_W'($urandom);
            item.pixel_index <= ADDR_W'($urandom);
            item.pixel_value <= PIX_W'($urandom);
        end
        @(negedge clk);
        item.valid <= 1'b1;
        item.cmd <= op;
        item.pixel_index <= idx;
        item.pixel_value <= pix;
        #1;
        while (!item.ready)
        begin
            @(negedge clk);
            #1;
        end
        predict_word(op, idx, pix);
        items_sent++;
        if (op == CMD_XFORM)
            xforms_sent++;
        if (op == CMD_READ)
            reads_sent++;
        @(posedge clk);
    endtask

    task automatic drop_item();
        @(negedge clk);
        item.valid <= 1'b0;
    endtask

    // Wait until every expected word is in, then let the block settle
    task automatic drain();
        drop_item();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Register write, only while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        #1;
        while (!cfg.ready)
        begin
            @(negedge clk);
            #1;
        end
        @(posedge clk);
        case (idx)
            REG_WIDTH:  cur_width = 32'(val);
            REG_HEIGHT: cur_height = 32'(val);
            REG_LEVELS: cur_levels = 32'(val[LVL_W-1:0]);
            default:    ;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_shape(int unsigned w, int unsigned h, int unsigned lv);
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_LEVELS, CFG_DATA_W'(lv));
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic int unsigned image_size();
        return dim_clip(cur_width, MAX_WIDTH) * dim_clip(cur_height, MAX_HEIGHT);
    endfunction

    // Load the whole image, transform, read back some coefficients
    task automatic run_frame(int n_reads);
        int unsigned total;
        int unsigned idx;
        total = image_size();
        for (int i = 0; i < total; i++)
        begin
            send_word(CMD_LOAD, ADDR_W'(i), pick_pixel());
            if ($urandom_range(19) == 0)
                send_word(CMD_NOP, ADDR_W'($urandom), PIX_W'($urandom));
        end
        send_word(CMD_XFORM, ADDR_W'($urandom), PIX_W'($urandom));
        for (int i = 0; i < n_reads; i++)
        begin
            case ($urandom_range(9))
                0:
                    send_word(CMD_NOP, ADDR_W'($urandom), PIX_W'($urandom));
                1:
                begin
                    // stray load anywhere; it only touches the source store
                    idx = $urandom_range(DEPTH - 1);
                    send_word(CMD_LOAD, ADDR_W'(idx), pick_pixel());
                end
                default:
                begin
                    idx = $urandom_range(DEPTH - 1);
                    if (!res_ok[idx])
                        idx = $urandom_range(total - 1);
                    send_word(CMD_READ, ADDR_W'(idx), PIX_W'($urandom));
                end
            endcase
        end
    endtask

    // Result checker: set ready at the falling edge, check the word taken
    initial
    begin
        result_word_t exp_word;
        mismatches = 0;
        words_checked = 0;
        result.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            result.ready <= ($urandom_range(99) >= recv_stall_pct);
            #1;
            if (rst_n && result.valid && result.ready)
            begin
                words_checked++;
                if (pending_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word coef=%0d done=%0b",
                                 result.coefficient, result.transform_done);
                end
                else
                begin
                    exp_word = pending_words.pop_front();
                    if (result.coefficient !== exp_word.coefficient ||
                        result.transform_done !== exp_word.transform_done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: coef exp %0d got %0d, done exp %0b got %0b",
                                     $signed(exp_word.coefficient), result.coefficient,
                                     exp_word.transform_done, result.transform_done);
                    end
                end
            end
        end
    end

    // Extremes of pixel values, every command, passthrough with zero levels
    task automatic test_directed();
        logic [PIX_W-1:0] pix_set [8];
        pix_set = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                    16'hFFFF, 16'h0000, 16'h0001, 16'h8000};
        set_shape(2, 4, 2);
        for (int i = 0; i < 8; i++)
            send_word(CMD_LOAD, ADDR_W'(i), pix_set[i]);
        send_word(CMD_NOP, '1, '1);
        send_word(CMD_XFORM, '0, '0);
        for (int i = 0; i < 8; i++)
            send_word(CMD_READ, ADDR_W'(i), '0);
        // zero levels only copies the image
        write_reg(REG_LEVELS, CFG_DATA_W'(0));
        send_word(CMD_XFORM, '1, '1);
        send_word(CMD_READ, ADDR_W'(3), '0);
        send_word(CMD_READ, ADDR_W'(7), '0);
    endtask

    // Largest and clamped dimensions, deepest levels, odd edges
    task automatic test_edges();
        set_shape(255, 0, 7);
        run_frame(24);
        set_shape(2, 128, 7);
        run_frame(24);
        set_shape(128, 1, 1);
        run_frame(10);
        set_shape(5, 3, 1);
        run_frame(15);
        set_shape(7, 7, 3);
        run_frame(20);
    endtask

    // Random frames of small shapes under one idling mode
    task automatic test_random(int gap_pct, int stall_pct, int item_goal);
        int start_items;
        drain();
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        start_items = items_sent;
        while (items_sent - start_items < item_goal)
        begin
            set_shape($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(0, 7));
            run_frame($urandom_range(8, 30));
        end
    endtask

    initial
    begin
        int quarter;
        rst_n = 1'b0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        xforms_sent = 0;
        reads_sent = 0;
        cur_width = 128;
        cur_height = 128;
        cur_levels = 1;
        item.valid <= 1'b0;
        item.cmd <= CMD_NOP;
        item.pixel_index <= '0;
        item.pixel_value <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        send_gap_pct = 20;
        recv_stall_pct = 20;
        test_edges();
        quarter = (ITEM_TARGET - items_sent) / 4;
        if (quarter < 40)
            quarter = 40;
        test_random(0, 0, quarter);
        test_random(66, 0, quarter);
        test_random(0, 66, quarter);
        test_random(6, 6, quarter);
        drain();
        repeat (20) @(posedge clk);

        $display("Sent %0d words: %0d transforms, %0d reads; checked %0d results",
                 items_sent, xforms_sent, reads_sent, words_checked);
        $display("Shapes from 2x2 to 128 wide or tall, 0 to 7 levels, four idle modes");
        if (mismatches == 0 && pending_words.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d words missing", mismatches, pending_words.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
